@@ design/b58enc_pkg.sv @@
package b58enc_pkg;

  localparam int MAX_BYTES   = 32;
  localparam int DIGIT_SLOTS = 45;
  localparam int OUT_CAP     = 45;

  localparam int IDX_W  = $clog2(DIGIT_SLOTS);
  localparam int NDIG_W = $clog2(DIGIT_SLOTS + 1);
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  localparam int TOT_W  = $clog2(MAX_BYTES + DIGIT_SLOTS + 1);
  localparam int LEN_W  = 6;
  localparam int CHAR_W = 7;

  // x / 58 as (x * RECIP) >> RECIP_SH, exact for x < 2^14
  localparam int RECIP    = 18079;
  localparam int RECIP_SH = 20;
  localparam int RADIX    = 58;
  localparam int X_W      = 14;
  localparam int PROD_W   = 29;

  localparam logic [CHAR_W-1:0] CHAR_ONE = 7'd49;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD_START,
    S_FOLD,
    S_EMIT_START,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic fold_start;
    logic fold_step;
    logic emit_start;
    logic emit_read;
    logic load_out;
    logic emit_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic fold_needed;
    logic last_in;
    logic last_held;
    logic fold_more;
    logic emit_empty;
    logic emit_final;
    logic out_taken;
  } status_t;

  // alphabet skips 0, I, O and l
  function automatic logic [CHAR_W-1:0] b58_char(input logic [5:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {1'b0, d};
    priority if (d < 6'd9) begin
      b58_char = 7'd49 + dw;
    end else if (d < 6'd17) begin
      b58_char = 7'd56 + dw;
    end else if (d < 6'd22) begin
      b58_char = 7'd57 + dw;
    end else if (d < 6'd33) begin
      b58_char = 7'd58 + dw;
    end else if (d < 6'd44) begin
      b58_char = 7'd64 + dw;
    end else if (d < 6'd58) begin
      b58_char = 7'd65 + dw;
    end else begin
      b58_char = 7'd49 + 7'(d - 6'd58);
    end
  endfunction

endpackage

@@ design/b58enc_ctrl.sv @@
module b58enc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  b58enc_pkg::status_t sts,
  output b58enc_pkg::cmd_t    cmd
);
  import b58enc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.fold_needed) begin
            state_nxt = S_FOLD_START;
          end else if (sts.last_in) begin
            state_nxt = S_EMIT_START;
          end
        end
      end
      S_FOLD_START: state_nxt = S_FOLD;
      S_FOLD: begin
        if (!sts.fold_more) begin
          state_nxt = sts.last_held ? S_EMIT_START : S_IDLE;
        end
      end
      S_EMIT_START: state_nxt = sts.emit_empty ? S_IDLE : S_EMIT_RD;
      S_EMIT_RD:    state_nxt = S_EMIT_OUT;
      S_EMIT_OUT:   state_nxt = S_EMIT_WAIT;
      S_EMIT_WAIT: begin
        if (sts.out_taken) begin
          state_nxt = sts.emit_final ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_FOLD_START: cmd.fold_start = 1'b1;
      S_FOLD:       cmd.fold_step  = 1'b1;
      S_EMIT_START: begin
        cmd.emit_start = 1'b1;
        cmd.clear      = sts.emit_empty;
      end
      S_EMIT_RD:  cmd.emit_read = 1'b1;
      S_EMIT_OUT: cmd.load_out  = 1'b1;
      S_EMIT_WAIT: begin
        cmd.emit_next = sts.out_taken;
        cmd.clear     = sts.out_taken & sts.emit_final;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ design/b58enc_dp.sv @@
module b58enc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  b58enc_pkg::cmd_t                    cmd,
  output b58enc_pkg::status_t                 sts,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [b58enc_pkg::CHAR_W-1:0]       out_char,
  output logic                                out_last_char,
  output logic [b58enc_pkg::LEN_W-1:0]        out_total_length,
  output logic                                out_overflowed
);
  import b58enc_pkg::*;

  // digit memory
  logic [5:0]       mem [DIGIT_SLOTS];
  logic [5:0]       rdata_r;
  logic             rd_ok_r;
  logic             mem_re;
  logic [IDX_W-1:0] mem_ra;

  // message bookkeeping
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] lzc_r;
  logic             seen_r;
  logic             region_r;
  logic             ovf_r;
  logic             last_r;
  logic [IDX_W-1:0] top_r;

  // fold
  logic [7:0]       carry_r;
  logic [IDX_W-1:0] pos_r;

  // emission
  logic [LEN_W-1:0] emitted_r;
  logic [LEN_W-1:0] k_r;
  logic [IDX_W-1:0] rpos_r;

  logic             out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic             out_last_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_ovf_r;

  logic              cnt_full;
  logic              zero_lead;
  logic [5:0]        dig;
  logic [X_W-1:0]    x_w;
  logic [PROD_W-1:0] prod_w;
  logic [7:0]        quo_w;
  logic [X_W-1:0]    rem_w;
  logic [NDIG_W-1:0] ndig_w;
  logic [TOT_W-1:0]  total_w;
  logic [LEN_W-1:0]  emitted_w;
  logic              k_in_lead;

  assign cnt_full  = cnt_r >= CNT_W'(MAX_BYTES);
  assign zero_lead = !seen_r && (in_data_byte == 8'd0);

  // one digit: (256 * d + carry) split into digit and carry
  assign dig    = rd_ok_r ? rdata_r : 6'd0;
  assign x_w    = {dig, carry_r};
  assign prod_w = PROD_W'(x_w) * PROD_W'(RECIP);
  assign quo_w  = prod_w[RECIP_SH+7:RECIP_SH];
  assign rem_w  = x_w - (X_W'(quo_w) * X_W'(RADIX));

  assign ndig_w    = seen_r ? (NDIG_W'(DIGIT_SLOTS) - NDIG_W'(top_r)) : '0;
  assign total_w   = TOT_W'(lzc_r) + TOT_W'(ndig_w);
  assign emitted_w = (total_w > TOT_W'(OUT_CAP)) ? LEN_W'(OUT_CAP) : LEN_W'(total_w);
  assign k_in_lead = k_r < LEN_W'(lzc_r);

  assign sts.fold_needed = !cnt_full && !zero_lead;
  assign sts.last_in     = in_last_byte;
  assign sts.last_held   = last_r;
  assign sts.fold_more   = (pos_r != '0) &&
                           ((region_r && (pos_r > top_r)) || (quo_w != 8'd0));
  assign sts.emit_empty  = emitted_w == '0;
  assign sts.emit_final  = (k_r + LEN_W'(1)) == emitted_r;
  assign sts.out_taken   = out_valid_r && out_ready;

  always_comb begin
    mem_re = 1'b0;
    mem_ra = pos_r;
    if (cmd.fold_start) begin
      mem_re = 1'b1;
      mem_ra = pos_r;
    end else if (cmd.fold_step) begin
      mem_re = 1'b1;
      mem_ra = pos_r - IDX_W'(1);
    end else if (cmd.emit_read) begin
      mem_re = 1'b1;
      mem_ra = rpos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fold_step) begin
      mem[pos_r] <= rem_w[5:0];
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fold_start) begin
      rd_ok_r <= region_r && (pos_r >= top_r);
    end else if (cmd.fold_step) begin
      rd_ok_r <= region_r && (pos_r > top_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      lzc_r    <= '0;
      seen_r   <= 1'b0;
      region_r <= 1'b0;
      ovf_r    <= 1'b0;
      last_r   <= 1'b0;
      top_r    <= IDX_W'(DIGIT_SLOTS - 1);
    end else if (cmd.clear) begin
      cnt_r  <= '0;
      lzc_r  <= '0;
      seen_r <= 1'b0;
      ovf_r  <= 1'b0;
      top_r  <= IDX_W'(DIGIT_SLOTS - 1);
    end else if (cmd.accept) begin
      last_r <= in_last_byte;
      if (cnt_full) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (zero_lead) begin
          lzc_r <= lzc_r + CNT_W'(1);
        end else begin
          region_r <= seen_r;
          seen_r   <= 1'b1;
        end
      end
    end else if (cmd.fold_step && !sts.fold_more) begin
      top_r <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      carry_r <= in_data_byte;
      pos_r   <= IDX_W'(DIGIT_SLOTS - 1);
    end else if (cmd.fold_step) begin
      carry_r <= quo_w;
      pos_r   <= pos_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      emitted_r <= emitted_w;
      k_r       <= '0;
      rpos_r    <= top_r;
    end else if (cmd.emit_next) begin
      k_r <= k_r + LEN_W'(1);
      if (!k_in_lead) begin
        rpos_r <= rpos_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (sts.out_taken) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_char_r <= k_in_lead ? CHAR_ONE : b58_char(rdata_r);
      out_last_r <= sts.emit_final;
      out_len_r  <= emitted_r;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_last_char    = out_last_r;
  assign out_total_length = out_len_r;
  assign out_overflowed   = out_ovf_r;

endmodule

@@ design/base58_encoder_unit.sv @@
// Base58 encoder (bitcoin alphabet): takes a message one byte a request, most significant
// first, with in_last_byte on the final byte, and returns the encoded string one character
// a request, leading '1's first, with the last-character flag, the string length and an
// overflow flag on every character. Bytes past 32 are dropped and flag overflow. A leading
// zero byte or a dropped byte is taken without a fold; any other byte is folded into the n
// base-58 digits it touches (up to 45), one digit per cycle through the digit memory's read
// and write ports. After the final byte a setup state sizes the string, then each character
// is read, loaded into the output register and held until out_ready takes it. The digit
// memory needs no clearing after reset or between messages.
module base58_encoder_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [b58enc_pkg::CHAR_W-1:0]       out_char,
  output logic                                out_last_char,
  output logic [b58enc_pkg::LEN_W-1:0]        out_total_length,
  output logic                                out_overflowed
);
  import b58enc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  b58enc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  b58enc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .out_last_char    (out_last_char),
    .out_total_length (out_total_length),
    .out_overflowed   (out_overflowed)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import b58enc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic              ovf;
  } b58_char_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_data_byte = 8'h00;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              out_last_char;
  logic [LEN_W-1:0]  out_total_length;
  logic              out_overflowed;

  base58_encoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .out_last_char    (out_last_char),
    .out_total_length (out_total_length),
    .out_overflowed   (out_overflowed)
  );

  string     b58_alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  b58_char_t pending_chars[$];
  logic [7:0] msg_buf[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatches = 0;
  int        cycle_cnt = 0;

  // encoder state mirror
  logic [5:0] digits[DIGIT_SLOTS];
  int         zero_run;
  bit         nonzero_seen;
  int         top_idx;
  int         byte_cnt;
  bit         ovf_seen;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic void clear_encoder_state();
    for (int i = 0; i < DIGIT_SLOTS; i++) digits[i] = 6'd0;
    zero_run = 0;
    nonzero_seen = 1'b0;
    top_idx = DIGIT_SLOTS - 1;
    byte_cnt = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void predict_byte(input logic [7:0] data, input logic last);
    int        carry;
    int        pos;
    int        lowest;
    bit        region;
    int        total;
    int        emitted;
    b58_char_t c;
    if (byte_cnt >= MAX_BYTES) begin
      ovf_seen = 1'b1;
    end else begin
      byte_cnt++;
      if (!nonzero_seen && data == 8'h00) begin
        zero_run++;
      end else begin
        carry = data;
        lowest = DIGIT_SLOTS - 1;
        region = nonzero_seen;
        pos = DIGIT_SLOTS - 1;
        while (pos >= 0 && ((region && pos >= top_idx) || carry != 0)) begin
          carry = carry + 256 * digits[pos];
          digits[pos] = 6'(carry % 58);
          carry = carry / 58;
          lowest = pos;
          pos--;
        end
        top_idx = lowest;
        nonzero_seen = 1'b1;
      end
    end
    if (last) begin
      total = zero_run + (nonzero_seen ? (DIGIT_SLOTS - top_idx) : 0);
      emitted = (total > OUT_CAP) ? OUT_CAP : total;
      for (int k = 0; k < emitted; k++) begin
        if (k < zero_run) c.ch = CHAR_ONE;
        else c.ch = CHAR_W'(b58_alphabet[digits[top_idx + k - zero_run]]);
        c.last = (k + 1 == emitted);
        c.len = LEN_W'(emitted);
        c.ovf = ovf_seen;
        pending_chars.push_back(c);
      end
      clear_encoder_state();
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  always @(posedge clk) begin : check_chars
    b58_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected char %0d", out_char));
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch || out_last_char !== want.last ||
            out_total_length !== want.len || out_overflowed !== want.ovf) begin
          note_mismatch($sformatf(
            "expected ch=%0d last=%0b len=%0d ovf=%0b, got ch=%0d last=%0b len=%0d ovf=%0b",
            want.ch, want.last, want.len, want.ovf,
            out_char, out_last_char, out_total_length, out_overflowed));
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(data, last);
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_buf.size(); i++) begin
      send_byte(msg_buf[i], i == msg_buf.size() - 1);
    end
    msg_buf.delete();
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_bytes();
    logic [7:0] vals[5] = '{8'h00, 8'hFF, 8'h01, 8'h39, 8'h3A};
    foreach (vals[i]) begin
      msg_buf.push_back(vals[i]);
      send_msg();
    end
  endtask

  task automatic test_leading_zeros();
    msg_buf = {8'h00, 8'h00, 8'h01};
    send_msg();
    msg_buf = {8'h00, 8'hFF, 8'hFF};
    send_msg();
  endtask

  task automatic test_all_zero();
    msg_buf = {8'h00, 8'h00, 8'h00, 8'h00};
    send_msg();
  endtask

  // full-size message of ones, then two extra bytes that get dropped
  task automatic test_overflow();
    for (int i = 0; i < MAX_BYTES + 2; i++) msg_buf.push_back(8'hFF);
    send_msg();
  endtask

  task automatic test_random(input int n_items);
    int  sent;
    int  kind;
    int  len;
    int  zeros;
    int  r;
    bit  all_zero;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      zeros = 0;
      all_zero = 1'b0;
      if (kind < 3) begin
        len = $urandom_range(30, 36);
        all_zero = 1'b1;
      end else if (kind < 10) begin
        len = $urandom_range(28, 38);
        zeros = $urandom_range(0, 2);
      end else if (kind < 17) begin
        len = $urandom_range(1, 6);
        all_zero = 1'b1;
      end else if (kind < 35) begin
        len = $urandom_range(2, 8);
        zeros = $urandom_range(1, 3);
      end else begin
        len = $urandom_range(1, 8);
      end
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        if (all_zero || i < zeros || r == 0) msg_buf.push_back(8'h00);
        else if (r == 1) msg_buf.push_back(8'hFF);
        else msg_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_msg();
      sent += len;
      if ($urandom_range(0, 19) == 0) wait_drain();
    end
  endtask

  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 66;
    clear_encoder_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_bytes();
    test_leading_zeros();
    test_all_zero();
    test_overflow();
    wait_drain();

    test_random(100);
    send_idle_pct = 66;
    recv_idle_pct = 34;
    test_random(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(100);

    wait_drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ base58_encoder_unit.f @@
design/b58enc_pkg.sv
design/b58enc_ctrl.sv
design/b58enc_dp.sv
design/base58_encoder_unit.sv
dv/tb_top.sv
